// ----- rtl/rsq_pkg.sv -----
// shared types and constants for the range sample qualifier
package rsq_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_BUS_ERR = 2'd1,
        MODE_UPDATE  = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        HEALTH_NOT_CONNECTED = 3'd0,
        HEALTH_NO_DATA       = 3'd1,
        HEALTH_OUT_LOW       = 3'd2,
        HEALTH_OUT_HIGH      = 3'd3,
        HEALTH_GOOD          = 3'd4
    } t_health;

    // how the pending quality is formed at publish time
    typedef enum logic [1:0] {
        QSEL_UNKNOWN = 2'd0,
        QSEL_FULL    = 2'd1,
        QSEL_ZERO    = 2'd2,
        QSEL_SCALED  = 2'd3
    } t_qsel;

    typedef enum logic [1:0] {
        REG_MIN_DIST = 2'd0,
        REG_MAX_DIST = 2'd1,
        REG_TIMEOUT  = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    localparam int DIST_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int TIMEOUT_W = 16;
    localparam int QUAL_W    = 8;
    localparam int SIGMA_W   = 32;
    localparam int TIME_W    = 32;
    localparam int CODE_W    = 8;
    localparam int SPAN_W    = 22;   // sigma window width in raw units
    localparam int SCALE_W   = 13;   // 100*span >> 16, at most 4500
    localparam int RECIP_W   = 15;
    localparam int RECIP_SH  = 20;

    localparam logic [SIGMA_W-1:0] SIGMA_LOW_RAW  = 32'd327680;
    localparam logic [SIGMA_W-1:0] SIGMA_HIGH_RAW = 32'd3276800;
    // ceil(2^20 / 45): floor(y/45) for y up to 4500
    localparam logic [RECIP_W-1:0] RECIP_45       = 15'd23302;

    localparam logic [CODE_W-1:0] CODE_VALID_A = 8'd0;
    localparam logic [CODE_W-1:0] CODE_VALID_B = 8'd3;
    localparam logic [CODE_W-1:0] CODE_VALID_C = 8'd6;

    localparam logic [QUAL_W-1:0] QUAL_UNKNOWN = 8'hFF;
    localparam logic [QUAL_W-1:0] QUAL_FULL    = 8'd100;
    localparam logic [QUAL_W-1:0] QUAL_ZERO    = 8'd0;

    localparam logic [LIMIT_W-1:0]   MIN_DIST_RST = 15'd20;
    localparam logic [LIMIT_W-1:0]   MAX_DIST_RST = 15'd4000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd500;

endpackage

// ----- rtl/range_sample_qualifier.sv -----
// range sample qualifier: grades range samples and tracks sensor health
// One request is accepted per clock cycle when the result side keeps up.
// A request passes through an input register; an update request then loads
// its result into the result register. Sample and bus-error requests give
// no result and never wait on the result side; an update request waits in
// the input register only while a previous result sits stalled in the
// result register. The sigma to quality scaling is split across two
// registers: the 100x scaling happens when a sample is stored, the divide
// by 45 (reciprocal multiply) happens when it is published. The user must
// write registers over the APB port while idle; the block never enforces it.
module range_sample_qualifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic signed [15:0]           i_range_mm,
    input  logic [7:0]                   i_range_code,
    input  logic [31:0]                  i_sigma_raw,
    input  logic [31:0]                  i_now_ms,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_health,
    output logic signed [15:0]           o_distance_mm,
    output logic signed [7:0]            o_quality_pct
);
    import rsq_pkg::*;

    // configuration registers
    logic [LIMIT_W-1:0]   r_min_dist;
    logic [LIMIT_W-1:0]   r_max_dist;
    logic [TIMEOUT_W-1:0] r_timeout;

    // input register
    logic                 r_in_vld;
    t_mode                r_in_mode;
    logic [DIST_W-1:0]    r_in_range;
    logic [CODE_W-1:0]    r_in_code;
    logic [SIGMA_W-1:0]   r_in_sigma;
    logic [TIME_W-1:0]    r_in_now;

    // pending sample
    logic [DIST_W-1:0]    r_pend_dist;
    t_qsel                r_pend_qsel;
    logic [SCALE_W-1:0]   r_pend_scale;
    logic [TIME_W-1:0]    r_pend_time;
    logic                 r_pend_valid;
    logic                 r_have_pend;
    logic                 r_bus_lost;

    // published state
    t_health              r_pub_health;
    logic [DIST_W-1:0]    r_pub_dist;
    logic [QUAL_W-1:0]    r_pub_qual;
    logic [TIME_W-1:0]    r_last_time;

    // result register
    logic                 r_out_vld;
    logic [2:0]           r_out_health;
    logic [DIST_W-1:0]    r_out_dist;
    logic [QUAL_W-1:0]    r_out_qual;

    logic                 cfg_wr;
    t_reg_idx             cfg_idx;
    logic                 out_free;
    logic                 proc_go;
    logic                 in_take;
    logic                 is_sample;
    logic                 is_bus_err;
    logic                 is_update;

    logic [SPAN_W-1:0]    sigma_span;
    logic [SPAN_W+6:0]    span_x100;
    t_qsel                n_pend_qsel;
    logic [SCALE_W-1:0]   n_pend_scale;
    logic                 code_ok;

    logic [SCALE_W+RECIP_W-1:0] scale_prod;
    logic [QUAL_W-1:0]    pend_qual;
    logic [TIME_W-1:0]    age;
    logic                 too_old;
    logic                 too_old_x2;
    logic                 below_min;
    logic                 above_max;
    t_health              n_pub_health;
    logic [DIST_W-1:0]    n_pub_dist;
    logic [QUAL_W-1:0]    n_pub_qual;
    logic [TIME_W-1:0]    n_last_time;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_MIN_DIST: prdata = {17'd0, r_min_dist};
            REG_MAX_DIST: prdata = {17'd0, r_max_dist};
            REG_TIMEOUT:  prdata = {16'd0, r_timeout};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIN_DIST_RST;
            r_max_dist <= MAX_DIST_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MIN_DIST: r_min_dist <= pwdata[LIMIT_W-1:0];
                REG_MAX_DIST: r_max_dist <= pwdata[LIMIT_W-1:0];
                REG_TIMEOUT:  r_timeout  <= pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign out_free   = !r_out_vld || !i_out_stall;
    assign is_sample  = (r_in_mode == MODE_SAMPLE);
    assign is_bus_err = (r_in_mode == MODE_BUS_ERR);
    assign is_update  = (r_in_mode == MODE_UPDATE);
    assign proc_go    = r_in_vld && (!is_update || out_free);
    assign o_in_stall = r_in_vld && !proc_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (proc_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode  <= t_mode'(i_mode);
            r_in_range <= i_range_mm;
            r_in_code  <= i_range_code;
            r_in_sigma <= i_sigma_raw;
            r_in_now   <= i_now_ms;
        end
    end

    // sigma classification and first scaling step (100 * span >> 16)
    assign code_ok = (r_in_code == CODE_VALID_A) || (r_in_code == CODE_VALID_B)
                  || (r_in_code == CODE_VALID_C);
    assign sigma_span = SPAN_W'(SIGMA_HIGH_RAW - r_in_sigma);
    assign span_x100  = {sigma_span, 6'd0} + {1'b0, sigma_span, 5'd0}
                      + {4'd0, sigma_span, 2'd0};

    always_comb begin
        n_pend_scale = span_x100[SPAN_W+6:16];
        priority if (r_in_sigma == '0) begin
            n_pend_qsel = QSEL_UNKNOWN;
        end else if (r_in_sigma < SIGMA_LOW_RAW) begin
            n_pend_qsel = QSEL_FULL;
        end else if (r_in_sigma > SIGMA_HIGH_RAW) begin
            n_pend_qsel = QSEL_ZERO;
        end else begin
            n_pend_qsel = QSEL_SCALED;
        end
    end

    // publish path: divide the stored scale by 45
    assign scale_prod = r_pend_scale * RECIP_45;

    always_comb begin
        unique case (r_pend_qsel)
            QSEL_UNKNOWN: pend_qual = QUAL_UNKNOWN;
            QSEL_FULL:    pend_qual = QUAL_FULL;
            QSEL_ZERO:    pend_qual = QUAL_ZERO;
            QSEL_SCALED:  pend_qual = scale_prod[RECIP_SH+QUAL_W-1:RECIP_SH];
            default:      pend_qual = QUAL_ZERO;
        endcase
    end

    assign age        = r_in_now - r_last_time;
    assign too_old    = age > {16'd0, r_timeout};
    assign too_old_x2 = age > {15'd0, r_timeout, 1'b0};
    assign below_min  = $signed(r_pend_dist) < $signed({1'b0, r_min_dist});
    assign above_max  = $signed(r_pend_dist) > $signed({1'b0, r_max_dist});

    always_comb begin
        n_pub_health = r_pub_health;
        n_pub_dist   = r_pub_dist;
        n_pub_qual   = r_pub_qual;
        n_last_time  = r_last_time;
        if (r_have_pend) begin
            n_pub_dist  = r_pend_dist;
            n_last_time = r_pend_time;
            if (r_pend_valid) begin
                n_pub_qual = pend_qual;
                priority if (below_min) begin
                    n_pub_health = HEALTH_OUT_LOW;
                end else if (above_max) begin
                    n_pub_health = HEALTH_OUT_HIGH;
                end else begin
                    n_pub_health = HEALTH_GOOD;
                end
            end else begin
                n_pub_qual   = QUAL_ZERO;
                n_pub_health = HEALTH_NO_DATA;
            end
        end else if (r_bus_lost) begin
            n_pub_health = too_old_x2 ? HEALTH_NOT_CONNECTED : HEALTH_NO_DATA;
            n_pub_qual   = QUAL_ZERO;
        end else if (too_old) begin
            n_pub_health = HEALTH_NO_DATA;
            n_pub_qual   = QUAL_ZERO;
        end
    end

    // pending sample and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pend  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_bus_lost   <= 1'b0;
        end else if (proc_go) begin
            if (is_sample) begin
                r_have_pend  <= 1'b1;
                r_pend_valid <= code_ok;
                r_bus_lost   <= 1'b0;
            end else if (is_bus_err) begin
                r_bus_lost <= 1'b1;
            end else if (is_update) begin
                r_have_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && is_sample) begin
            r_pend_dist  <= r_in_range;
            r_pend_qsel  <= n_pend_qsel;
            r_pend_scale <= n_pend_scale;
            r_pend_time  <= r_in_now;
        end
    end

    // published state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_health <= HEALTH_NO_DATA;
            r_pub_dist   <= '0;
            r_pub_qual   <= '0;
            r_last_time  <= '0;
        end else if (proc_go && is_update) begin
            r_pub_health <= n_pub_health;
            r_pub_dist   <= n_pub_dist;
            r_pub_qual   <= n_pub_qual;
            r_last_time  <= n_last_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_go && is_update) begin
            r_out_vld <= 1'b1;
        end else if (out_free) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && is_update) begin
            r_out_health <= n_pub_health;
            r_out_dist   <= n_pub_dist;
            r_out_qual   <= n_pub_qual;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_health      = r_out_health;
    assign o_distance_mm = r_out_dist;
    assign o_quality_pct = r_out_qual;

endmodule

// ----- tb/tb_range_sample_qualifier.sv -----
// testbench for the range sample qualifier: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_range_sample_qualifier;
    import rsq_pkg::*;

    typedef struct {
        t_health            health;
        logic signed [15:0] distance;
        logic signed [7:0]  qual;
    } t_health_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_mode;
    logic signed [15:0] i_range_mm;
    logic [7:0]         i_range_code;
    logic [31:0]        i_sigma_raw;
    logic [31:0]        i_now_ms;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_health;
    logic signed [15:0] o_distance_mm;
    logic signed [7:0]  o_quality_pct;

    range_sample_qualifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_range_mm    (i_range_mm),
        .i_range_code  (i_range_code),
        .i_sigma_raw   (i_sigma_raw),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_health      (o_health),
        .o_distance_mm (o_distance_mm),
        .o_quality_pct (o_quality_pct)
    );

    // predictor copy of the configuration
    logic [14:0] cfg_min;
    logic [14:0] cfg_max;
    logic [15:0] cfg_timeout;

    // predictor copy of the block state
    logic signed [15:0] smp_dist;
    logic signed [7:0]  smp_qual;
    logic [31:0]        smp_time;
    logic               smp_ok;
    logic               smp_held;
    logic               link_lost;
    t_health            rep_health;
    logic signed [15:0] rep_dist;
    logic signed [7:0]  rep_qual;
    logic [31:0]        rep_time;

    t_health_report due_reports[$];
    int             errors;
    int             sender_idle_pct;
    int             recv_stall_pct;
    int             hold_len;
    logic [31:0]    clock_ms;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [7:0] sigma_to_quality(input logic [31:0] raw);
        longint unsigned num;
        if (raw == 32'd0)
            return -8'sd1;
        if (raw < SIGMA_LOW_RAW)
            return 8'sd100;
        if (raw > SIGMA_HIGH_RAW)
            return 8'sd0;
        num = 64'd100 * (64'd3276800 - 64'(raw));
        return 8'(num / 64'd2949120);
    endfunction

    // advances the predicted state by one request; returns 1 when a report is due
    function automatic bit qualify_request(input t_mode m, input logic signed [15:0] rng,
                                           input logic [7:0] code, input logic [31:0] sigma,
                                           input logic [31:0] now, output t_health_report rep);
        logic [31:0] age;
        int          d;
        rep = '{HEALTH_NO_DATA, 16'sd0, 8'sd0};
        case (m)
            MODE_SAMPLE: begin
                smp_dist  = rng;
                smp_qual  = sigma_to_quality(sigma);
                smp_time  = now;
                smp_ok    = (code == CODE_VALID_A) || (code == CODE_VALID_B) ||
                            (code == CODE_VALID_C);
                smp_held  = 1'b1;
                link_lost = 1'b0;
                return 1'b0;
            end
            MODE_BUS_ERR: begin
                link_lost = 1'b1;
                return 1'b0;
            end
            MODE_UPDATE: begin
                if (smp_held) begin
                    rep_dist = smp_dist;
                    rep_time = smp_time;
                    if (smp_ok) begin
                        d = smp_dist;
                        rep_qual = smp_qual;
                        // low test wins when min is above max
                        if (d < int'(cfg_min))
                            rep_health = HEALTH_OUT_LOW;
                        else if (d > int'(cfg_max))
                            rep_health = HEALTH_OUT_HIGH;
                        else
                            rep_health = HEALTH_GOOD;
                    end else begin
                        rep_qual   = 8'sd0;
                        rep_health = HEALTH_NO_DATA;
                    end
                    smp_held = 1'b0;
                end else begin
                    age = now - rep_time;
                    if (link_lost) begin
                        rep_health = (age > 32'({cfg_timeout, 1'b0})) ? HEALTH_NOT_CONNECTED
                                                                      : HEALTH_NO_DATA;
                        rep_qual   = 8'sd0;
                    end else if (age > 32'(cfg_timeout)) begin
                        rep_health = HEALTH_NO_DATA;
                        rep_qual   = 8'sd0;
                    end
                end
                rep = '{rep_health, rep_dist, rep_qual};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // result side: random stall plus an optional long hold-off
    always @(posedge i_clk) begin
        int hold_cnt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (hold_len > 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0) begin
                i_out_stall <= 1'b1;
                hold_cnt = hold_cnt - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_health_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_reports.size() == 0) begin
                $display("%0t unexpected result health %0d dist %0d qual %0d",
                         $time, o_health, o_distance_mm, o_quality_pct);
                errors++;
            end else begin
                want = due_reports.pop_front();
                if (o_health !== want.health) begin
                    $display("%0t health mismatch exp %0d got %0d", $time, want.health, o_health);
                    errors++;
                end
                if (o_distance_mm !== want.distance) begin
                    $display("%0t distance mismatch exp %0d got %0d",
                             $time, want.distance, o_distance_mm);
                    errors++;
                end
                if (o_quality_pct !== want.qual) begin
                    $display("%0t quality mismatch exp %0d got %0d",
                             $time, want.qual, o_quality_pct);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(input t_mode m, input logic signed [15:0] rng,
                                input logic [7:0] code, input logic [31:0] sigma,
                                input logic [31:0] now);
        t_health_report rep;
        int             gap;
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_range_mm   <= rng;
        i_range_code <= code;
        i_sigma_raw  <= sigma;
        i_now_ms     <= now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (qualify_request(m, rng, code, sigma, now, rep))
            due_reports.push_back(rep);
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // waits until every report is back and the input register has emptied
    task automatic drain_pipeline;
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] readback;
        case (idx)
            REG_MIN_DIST: begin
                cfg_min  = value[14:0];
                readback = 32'(value[14:0]);
            end
            REG_MAX_DIST: begin
                cfg_max  = value[14:0];
                readback = 32'(value[14:0]);
            end
            default: begin
                cfg_timeout = value[15:0];
                readback    = 32'(value[15:0]);
            end
        endcase
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== readback) begin
            $display("%0t register %0d readback mismatch exp %0h got %0h",
                     $time, idx, readback, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [14:0] lo, input logic [14:0] hi,
                              input logic [15:0] tmo);
        drain_pipeline();
        write_register(REG_MIN_DIST, 32'(lo));
        write_register(REG_MAX_DIST, 32'(hi));
        write_register(REG_TIMEOUT, 32'(tmo));
    endtask

    task automatic test_directed;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        // update straight after reset, inside the timeout
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd100);
        send_request(MODE_SAMPLE, 16'sd1000, CODE_VALID_A, 32'd0, 32'd1000);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1001);
        send_request(MODE_SAMPLE, -16'sd32768, CODE_VALID_B, 32'd327679, 32'd1100);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1101);
        send_request(MODE_SAMPLE, 16'sd32767, CODE_VALID_C, 32'd327680, 32'd1200);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1201);
        send_request(MODE_SAMPLE, 16'sd20, CODE_VALID_A, 32'd3276800, 32'd1300);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1300);
        send_request(MODE_SAMPLE, 16'sd4000, CODE_VALID_A, 32'd3276801, 32'd1400);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1400);
        send_request(MODE_SAMPLE, 16'sd4001, CODE_VALID_C, 32'd1800000, 32'd1500);
        // invalid status code, then sample replaced before publish
        send_request(MODE_SAMPLE, 16'sd19, 8'd1, 32'hFFFF_FFFF, 32'd1600);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd1600);
        // timeouts without and with a lost bus
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd2100);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd2101);
        send_request(MODE_BUS_ERR, 16'sd0, 8'd0, 32'd0, 32'd2200);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd2600);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'd2601);
        // pending sample wins over a later bus error
        send_request(MODE_SAMPLE, 16'sd500, 8'd255, 32'd2000000, 32'hFFFF_FF00);
        send_request(MODE_BUS_ERR, 16'sd0, 8'd0, 32'd0, 32'hFFFF_FF01);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'hFFFF_FF02);
        // age across the time wrap
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'h0000_0010);
        send_request(MODE_UNUSED, 16'sd1, 8'd3, 32'd1, 32'h0000_0020);
        send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, 32'h0000_0300);
    endtask

    task automatic run_random(input int count);
        int                 done;
        int                 pick;
        t_mode              m;
        logic signed [15:0] rng;
        logic [7:0]         code;
        logic [31:0]        sigma;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 40)
                m = MODE_SAMPLE;
            else if (pick < 80)
                m = MODE_UPDATE;
            else if (pick < 94)
                m = MODE_BUS_ERR;
            else
                m = MODE_UNUSED;
            case ($urandom_range(3))
                0: rng = 16'($urandom);
                1: rng = 16'(int'(cfg_min) + int'($urandom_range(0, 4)) - 2);
                2: rng = 16'(int'(cfg_max) + int'($urandom_range(0, 4)) - 2);
                default: rng = 16'($urandom_range(0, 5000));
            endcase
            if ($urandom_range(1))
                code = 8'($urandom);
            else
                case ($urandom_range(2))
                    0: code = CODE_VALID_A;
                    1: code = CODE_VALID_B;
                    default: code = CODE_VALID_C;
                endcase
            case ($urandom_range(4))
                0: sigma = 32'd0;
                1: sigma = $urandom_range(1, 327680);
                2: sigma = $urandom_range(327679, 3276801);
                3: sigma = $urandom;
                default: sigma = $urandom_range(3276800, 32'h00FF_FFFF);
            endcase
            if ($urandom_range(15) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 2 * int'(cfg_timeout) + 20);
            send_request(m, rng, code, sigma, clock_ms);
            if (m != MODE_UNUSED)
                done++;
        end
    endtask

    task automatic test_default_limits;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_random(80);
    endtask

    task automatic test_wide_window;
        set_limits(15'd0, 15'd32767, 16'd1);
        sender_idle_pct = 45;
        recv_stall_pct  = 0;
        run_random(80);
    endtask

    task automatic test_crossed_window;
        // min above max and a zero timeout
        set_limits(15'd32767, 15'd0, 16'd0);
        sender_idle_pct = 0;
        recv_stall_pct  = 45;
        run_random(80);
    endtask

    task automatic test_long_timeout;
        set_limits(15'd100, 15'd2000, 16'd65535);
        sender_idle_pct = 18;
        recv_stall_pct  = 18;
        run_random(80);
    endtask

    task automatic test_backpressure;
        int n;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_len = 200;
        for (n = 0; n < 40; n++) begin
            clock_ms = clock_ms + $urandom_range(0, 50);
            if (n % 2 == 0)
                send_request(MODE_SAMPLE, 16'($urandom_range(0, 3000)), CODE_VALID_A,
                             $urandom_range(1, 4000000), clock_ms);
            else
                send_request(MODE_UPDATE, 16'sd0, 8'd0, 32'd0, clock_ms);
        end
    endtask

    initial begin
        errors          = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_len        = 0;
        clock_ms        = 32'd5000;
        cfg_min         = MIN_DIST_RST;
        cfg_max         = MAX_DIST_RST;
        cfg_timeout     = TIMEOUT_RST;
        smp_dist        = 16'sd0;
        smp_qual        = 8'sd0;
        smp_time        = 32'd0;
        smp_ok          = 1'b0;
        smp_held        = 1'b0;
        link_lost       = 1'b0;
        rep_health      = HEALTH_NO_DATA;
        rep_dist        = 16'sd0;
        rep_qual        = 8'sd0;
        rep_time        = 32'd0;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= 4'd0;
        pwdata       <= 32'd0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_SAMPLE;
        i_range_mm   <= 16'sd0;
        i_range_code <= 8'd0;
        i_sigma_raw  <= 32'd0;
        i_now_ms     <= 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_default_limits();
        test_wide_window();
        test_crossed_window();
        test_long_timeout();
        test_backpressure();
        drain_pipeline();
        repeat (4) @(posedge i_clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
